@@ rtl/mbd_pkg.sv @@
`timescale 1ns / 1ps
package mbd_pkg;

  localparam int BOUNDARY_BYTES = 48;
  localparam int IDX_W = $clog2(BOUNDARY_BYTES);
  localparam int LEN_W = $clog2(BOUNDARY_BYTES + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_LEARN   = 3'd0,
    PH_HEADERS = 3'd1,
    PH_CONTENT = 3'd2,
    PH_TRAIL1  = 3'd3,
    PH_TRAIL2  = 3'd4,
    PH_IDLE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    K_CONTENT   = 3'd0,
    K_HEADER    = 3'd1,
    K_FIELD_END = 3'd2,
    K_FORM_END  = 3'd3,
    K_ERROR     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_DECIDE,
    ST_FRD,
    ST_FOUT,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic sel_flush;
    logic flush_start;
    logic flush_step;
    logic clr_mc;
    logic emit_flush;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic flush_req;
    logic has_res;
    logic last_flush;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/mbd_ctrl.sv @@
`timescale 1ns / 1ps
module mbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mbd_pkg::sts_t sts,
  output mbd_pkg::cmd_t cmd
);

  mbd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbd_pkg::ST_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      mbd_pkg::ST_WAIT: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mbd_pkg::ST_DECIDE;
        end
      end
      mbd_pkg::ST_DECIDE: begin
        cmd.commit = 1'b1;
        if (sts.flush_req) begin
          cmd.flush_start = 1'b1;
          state_nxt       = mbd_pkg::ST_FRD;
        end else if (sts.has_res) begin
          state_nxt = mbd_pkg::ST_FINAL;
        end else begin
          state_nxt = mbd_pkg::ST_WAIT;
        end
      end
      mbd_pkg::ST_FRD: begin
        cmd.sel_flush = 1'b1;
        state_nxt     = mbd_pkg::ST_FOUT;
      end
      mbd_pkg::ST_FOUT: begin
        cmd.sel_flush = 1'b1;
        if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          if (sts.last_flush) begin
            cmd.clr_mc = 1'b1;
            state_nxt  = mbd_pkg::ST_FINAL;
          end else begin
            cmd.flush_step = 1'b1;
            state_nxt      = mbd_pkg::ST_FRD;
          end
        end
      end
      mbd_pkg::ST_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = mbd_pkg::ST_WAIT;
        end
      end
      default: state_nxt = mbd_pkg::ST_WAIT;
    endcase
  end

endmodule

@@ rtl/mbd_dpath.sv @@
`timescale 1ns / 1ps
module mbd_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_data_byte,
  input  logic          in_stream_end,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic [2:0]    out_kind,
  output logic          out_last,
  input  mbd_pkg::cmd_t cmd,
  output mbd_pkg::sts_t sts
);

  localparam int IW = mbd_pkg::IDX_W;
  localparam int LW = mbd_pkg::LEN_W;

  // boundary store; entries 0 and 1 are the fixed CR LF prefix
  logic [7:0] mem [mbd_pkg::BOUNDARY_BYTES];
  logic [7:0] rd_data_r;
  logic       rd_lo_r;
  logic       rd_bit0_r;
  logic [IW-1:0] rd_addr;
  logic [7:0] store_q;

  logic [7:0]      byte_r;
  logic            end_r;
  mbd_pkg::phase_t phase_r, phase_nxt;
  logic [LW-1:0]   blen_r, blen_nxt;
  logic [LW-1:0]   mc_r, mc_nxt;
  logic [7:0]      tf_r, tf_nxt;
  logic            pcr_r, pcr_nxt;
  logic [1:0]      ll_r, ll_nxt;
  logic [IW-1:0]   flush_idx_r;
  mbd_pkg::kind_t  fin_kind_r, fin_kind;
  logic [7:0]      fin_byte_r, fin_byte;
  logic            wr_en;
  logic            has_res;
  logic            flush_req;
  logic            is_cr;
  logic            is_lf;

  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  mbd_pkg::kind_t  out_kind_r;
  logic            out_last_r;

  assign rd_addr = cmd.sel_flush ? flush_idx_r : mc_r[IW-1:0];
  assign store_q = rd_lo_r ? (rd_bit0_r ? mbd_pkg::CH_LF : mbd_pkg::CH_CR) : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[blen_r[IW-1:0]] <= byte_r;
    end
    rd_data_r <= mem[rd_addr];
    rd_lo_r   <= (rd_addr < IW'(2));
    rd_bit0_r <= rd_addr[0];
  end

  assign is_cr = (byte_r == mbd_pkg::CH_CR);
  assign is_lf = (byte_r == mbd_pkg::CH_LF);

  always_comb begin
    phase_nxt = phase_r;
    blen_nxt  = blen_r;
    mc_nxt    = mc_r;
    tf_nxt    = tf_r;
    pcr_nxt   = pcr_r;
    ll_nxt    = ll_r;
    wr_en     = 1'b0;
    has_res   = 1'b0;
    flush_req = 1'b0;
    fin_kind  = mbd_pkg::K_CONTENT;
    fin_byte  = '0;
    if (end_r) begin
      if (phase_r != mbd_pkg::PH_IDLE) begin
        has_res   = 1'b1;
        fin_kind  = mbd_pkg::K_FORM_END;
        flush_req = (phase_r == mbd_pkg::PH_CONTENT) && (mc_r != '0);
      end
      phase_nxt = mbd_pkg::PH_IDLE;
    end else begin
      unique case (phase_r)
        mbd_pkg::PH_LEARN: begin
          if (is_lf) begin
            if (pcr_r && blen_r > LW'(2)) begin
              // drop the stored CR of the boundary line
              blen_nxt  = blen_r - LW'(1);
              phase_nxt = mbd_pkg::PH_HEADERS;
              ll_nxt    = '0;
              pcr_nxt   = 1'b0;
            end else begin
              has_res   = 1'b1;
              fin_kind  = mbd_pkg::K_ERROR;
              phase_nxt = mbd_pkg::PH_IDLE;
            end
          end else if (blen_r >= LW'(mbd_pkg::BOUNDARY_BYTES)) begin
            has_res   = 1'b1;
            fin_kind  = mbd_pkg::K_ERROR;
            phase_nxt = mbd_pkg::PH_IDLE;
          end else begin
            wr_en    = 1'b1;
            blen_nxt = blen_r + LW'(1);
            pcr_nxt  = is_cr;
          end
        end
        mbd_pkg::PH_HEADERS: begin
          if (is_lf && !pcr_r) begin
            has_res   = 1'b1;
            fin_kind  = mbd_pkg::K_ERROR;
            phase_nxt = mbd_pkg::PH_IDLE;
          end else begin
            has_res  = 1'b1;
            fin_kind = mbd_pkg::K_HEADER;
            fin_byte = byte_r;
            if (is_lf) begin
              // empty line ends the header block
              if (ll_r == 2'd1) begin
                phase_nxt = mbd_pkg::PH_CONTENT;
                mc_nxt    = '0;
              end
              ll_nxt  = '0;
              pcr_nxt = 1'b0;
            end else begin
              if (ll_r != 2'd3) begin
                ll_nxt = ll_r + 2'd1;
              end
              pcr_nxt = is_cr;
            end
          end
        end
        mbd_pkg::PH_CONTENT: begin
          if (mc_r < blen_r && byte_r == store_q) begin
            if (({1'b0, mc_r} + (LW+1)'(1)) >= {1'b0, blen_r}) begin
              has_res   = 1'b1;
              fin_kind  = mbd_pkg::K_FIELD_END;
              mc_nxt    = '0;
              phase_nxt = mbd_pkg::PH_TRAIL1;
            end else begin
              mc_nxt = mc_r + LW'(1);
            end
          end else begin
            // held bytes go out first, breaking byte last
            flush_req = (mc_r != '0);
            has_res   = 1'b1;
            fin_kind  = mbd_pkg::K_CONTENT;
            fin_byte  = byte_r;
          end
        end
        mbd_pkg::PH_TRAIL1: begin
          tf_nxt    = byte_r;
          phase_nxt = mbd_pkg::PH_TRAIL2;
        end
        mbd_pkg::PH_TRAIL2: begin
          if (tf_r == mbd_pkg::CH_CR && is_lf) begin
            phase_nxt = mbd_pkg::PH_HEADERS;
            ll_nxt    = '0;
            pcr_nxt   = 1'b0;
          end else begin
            has_res   = 1'b1;
            fin_kind  = mbd_pkg::K_FORM_END;
            phase_nxt = mbd_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = mbd_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_data_byte;
      end_r  <= in_stream_end;
    end
    if (cmd.commit) begin
      tf_r       <= tf_nxt;
      fin_kind_r <= fin_kind;
      fin_byte_r <= fin_byte;
    end
    if (cmd.flush_start) begin
      flush_idx_r <= '0;
    end else if (cmd.flush_step) begin
      flush_idx_r <= flush_idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mbd_pkg::PH_LEARN;
      blen_r  <= LW'(2);
      mc_r    <= '0;
      pcr_r   <= 1'b0;
      ll_r    <= '0;
    end else begin
      if (cmd.commit) begin
        phase_r <= phase_nxt;
        blen_r  <= blen_nxt;
        mc_r    <= mc_nxt;
        pcr_r   <= pcr_nxt;
        ll_r    <= ll_nxt;
      end else if (cmd.clr_mc) begin
        mc_r <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_flush || cmd.emit_final) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_flush) begin
      out_byte_r <= store_q;
      out_kind_r <= mbd_pkg::K_CONTENT;
      out_last_r <= 1'b0;
    end else if (cmd.emit_final) begin
      out_byte_r <= fin_byte_r;
      out_kind_r <= fin_kind_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

  assign sts.flush_req  = flush_req;
  assign sts.has_res    = has_res;
  assign sts.last_flush = (({1'b0, flush_idx_r} + (IW+1)'(1)) == (IW+1)'(mc_r));
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

@@ rtl/multipart_boundary_deframer.sv @@
`timescale 1ns / 1ps
// Multipart form body deframer: one body byte per input transfer, tagged content or
// header bytes and field-end, form-end and error markers per output transfer, with
// out_last on the final result of each input. A byte is accepted (ST_WAIT), decoded
// (ST_DECIDE) and its tagged byte or marker, if any, issued (ST_FINAL); each held
// partial-match byte released on a mismatch or stream end adds ST_FRD and ST_FOUT
// (one registered store read port). Output stall only adds waits. No clearing pass.
module multipart_boundary_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);

  mbd_pkg::cmd_t cmd;
  mbd_pkg::sts_t sts;

  mbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbd_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_data_byte  (in_data_byte),
    .in_stream_end (in_stream_end),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  localparam logic [15:0] PAIR_CRLF = 16'h0A0D;
  localparam logic [7:0] DASH = 8'h2D;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0] data;
    mbd_pkg::kind_t kind;
    logic last;
  } tag_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_data_byte;
  logic in_stream_end;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic out_last;

  // predicted deframer state
  mbd_pkg::phase_t form_phase;
  logic [7:0] delim [mbd_pkg::BOUNDARY_BYTES];
  int delim_len;
  int held;
  int line_len;
  logic [7:0] trail_first;
  logic saw_cr;

  tag_t tag_queue[$];
  tag_t want;
  int gap_pct;
  int stall_pct;
  int sent;
  int fail_count;
  int idle_cycles = 0;

  multipart_boundary_deframer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_stream_end(in_stream_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_kind(out_kind),
    .out_last(out_last)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic add_tag(input logic [7:0] b, input mbd_pkg::kind_t k);
    tag_queue.push_back('{data: b, kind: k, last: 1'b0});
  endtask

  task automatic release_held();
    for (int i = 0; i < held; i++) begin
      add_tag(delim[i], mbd_pkg::K_CONTENT);
    end
    held = 0;
  endtask

  // tags and markers produced by one accepted body byte
  task automatic deframe_step(input logic [7:0] b, input logic e);
    int first;
    first = tag_queue.size();
    if (e) begin
      if (form_phase != mbd_pkg::PH_IDLE) begin
        if (form_phase == mbd_pkg::PH_CONTENT) release_held();
        add_tag(8'h00, mbd_pkg::K_FORM_END);
      end
      form_phase = mbd_pkg::PH_IDLE;
      held = 0;
    end else begin
      case (form_phase)
        mbd_pkg::PH_LEARN: begin
          if (b == mbd_pkg::CH_LF) begin
            if (saw_cr && delim_len > 2) begin
              // drop the stored cr of the boundary line
              delim_len--;
              form_phase = mbd_pkg::PH_HEADERS;
              line_len = 0;
              saw_cr = 1'b0;
            end else begin
              add_tag(8'h00, mbd_pkg::K_ERROR);
              form_phase = mbd_pkg::PH_IDLE;
            end
          end else if (delim_len >= mbd_pkg::BOUNDARY_BYTES) begin
            add_tag(8'h00, mbd_pkg::K_ERROR);
            form_phase = mbd_pkg::PH_IDLE;
          end else begin
            delim[delim_len] = b;
            delim_len++;
            saw_cr = (b == mbd_pkg::CH_CR);
          end
        end
        mbd_pkg::PH_HEADERS: begin
          if (b == mbd_pkg::CH_LF) begin
            if (!saw_cr) begin
              add_tag(8'h00, mbd_pkg::K_ERROR);
              form_phase = mbd_pkg::PH_IDLE;
            end else begin
              add_tag(b, mbd_pkg::K_HEADER);
              if (line_len == 1) begin
                form_phase = mbd_pkg::PH_CONTENT;
                held = 0;
              end
              line_len = 0;
              saw_cr = 1'b0;
            end
          end else begin
            add_tag(b, mbd_pkg::K_HEADER);
            if (line_len < 3) line_len++;
            saw_cr = (b == mbd_pkg::CH_CR);
          end
        end
        mbd_pkg::PH_CONTENT: begin
          if (held < delim_len && b == delim[held]) begin
            held++;
            if (held >= delim_len) begin
              add_tag(8'h00, mbd_pkg::K_FIELD_END);
              held = 0;
              form_phase = mbd_pkg::PH_TRAIL1;
            end
          end else begin
            // breaking byte goes out as content without a new match attempt
            release_held();
            add_tag(b, mbd_pkg::K_CONTENT);
          end
        end
        mbd_pkg::PH_TRAIL1: begin
          trail_first = b;
          form_phase = mbd_pkg::PH_TRAIL2;
        end
        mbd_pkg::PH_TRAIL2: begin
          if ({b, trail_first} == PAIR_CRLF) begin
            form_phase = mbd_pkg::PH_HEADERS;
            line_len = 0;
            saw_cr = 1'b0;
          end else begin
            add_tag(8'h00, mbd_pkg::K_FORM_END);
            form_phase = mbd_pkg::PH_IDLE;
          end
        end
        default: begin
          form_phase = mbd_pkg::PH_IDLE;
        end
      endcase
    end
    if (tag_queue.size() > first) tag_queue[tag_queue.size() - 1].last = 1'b1;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_stream_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_step(b, e);
    sent++;
  endtask

  // any byte but lf, now and then a lone cr
  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    if ($urandom_range(0, 15) == 0) return mbd_pkg::CH_CR;
    do b = 8'($urandom_range(0, 255)); while (b == mbd_pkg::CH_LF);
    return b;
  endfunction

  task automatic hold_prefix(input int k);
    while (held < k && form_phase == mbd_pkg::PH_CONTENT) push_byte(delim[held], 1'b0);
  endtask

  // completes whatever match is under way
  task automatic close_field();
    while (form_phase == mbd_pkg::PH_CONTENT) push_byte(delim[held], 1'b0);
  endtask

  task automatic test_boundary_line();
    int chars;
    case ($urandom_range(0, 5))
      0: chars = 0;
      1: chars = mbd_pkg::BOUNDARY_BYTES - 3;
      default: chars = $urandom_range(1, 16);
    endcase
    repeat (chars) push_byte(pick_text(), 1'b0);
    push_byte(mbd_pkg::CH_CR, 1'b0);
    push_byte(mbd_pkg::CH_LF, 1'b0);
  endtask

  task automatic test_edge_bytes();
    int k;
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(mbd_pkg::CH_CR, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(mbd_pkg::CH_CR, 1'b0);
    push_byte(mbd_pkg::CH_LF, 1'b0);
    push_byte(mbd_pkg::CH_CR, 1'b0);
    push_byte(mbd_pkg::CH_LF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    k = (delim_len - 1 < 3) ? delim_len - 1 : 3;
    hold_prefix(k);
    // a cr (00 where the next boundary byte is cr) breaks the match and is not taken as a new match start
    push_byte((delim[held] != mbd_pkg::CH_CR) ? mbd_pkg::CH_CR : 8'h00, 1'b0);
    close_field();
    push_byte(mbd_pkg::CH_CR, 1'b0);
    push_byte(mbd_pkg::CH_LF, 1'b0);
  endtask

  task automatic run_form(input int n_items);
    int stop;
    int count;
    logic [7:0] b;
    stop = sent + n_items;
    while (sent < stop && form_phase != mbd_pkg::PH_IDLE) begin
      case (form_phase)
        mbd_pkg::PH_HEADERS: begin
          repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(1, 8)) push_byte(pick_text(), 1'b0);
            push_byte(mbd_pkg::CH_CR, 1'b0);
            push_byte(mbd_pkg::CH_LF, 1'b0);
          end
          push_byte(mbd_pkg::CH_CR, 1'b0);
          push_byte(mbd_pkg::CH_LF, 1'b0);
        end
        mbd_pkg::PH_CONTENT: begin
          count = $urandom_range(0, 24);
          while (count > 0 && form_phase == mbd_pkg::PH_CONTENT) begin
            count--;
            case ($urandom_range(0, 11))
              0: begin
                hold_prefix($urandom_range(1, delim_len - 1));
                b = 8'($urandom_range(0, 255));
                if (b == delim[held]) b = b ^ 8'h01;
                push_byte(b, 1'b0);
              end
              1: push_byte(mbd_pkg::CH_CR, 1'b0);
              default: push_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
          end
          close_field();
        end
        mbd_pkg::PH_TRAIL1: push_byte(mbd_pkg::CH_CR, 1'b0);
        mbd_pkg::PH_TRAIL2: push_byte(mbd_pkg::CH_LF, 1'b0);
        default: push_byte(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
  endtask

  task automatic test_drain_pause();
    in_valid <= 1'b0;
    while (tag_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_form_close();
    logic [7:0] b0;
    logic [7:0] b1;
    while (form_phase != mbd_pkg::PH_CONTENT && form_phase != mbd_pkg::PH_IDLE) begin
      if (form_phase == mbd_pkg::PH_TRAIL1) begin
        push_byte(mbd_pkg::CH_CR, 1'b0);
      end else if (form_phase == mbd_pkg::PH_TRAIL2) begin
        push_byte(mbd_pkg::CH_LF, 1'b0);
      end else begin
        push_byte(mbd_pkg::CH_CR, 1'b0);
        push_byte(mbd_pkg::CH_LF, 1'b0);
      end
    end
    case ($urandom_range(0, 3))
      0: begin
        // stream ends with a partial match held back
        hold_prefix($urandom_range(1, delim_len - 1));
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      1: begin
        close_field();
        push_byte(DASH, 1'b0);
        push_byte(DASH, 1'b0);
      end
      2: begin
        close_field();
        b0 = 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        if (b0 == mbd_pkg::CH_CR && b1 == mbd_pkg::CH_LF) b1 = 8'h00;
        push_byte(b0, 1'b0);
        push_byte(b1, 1'b0);
      end
      default: begin
        // lf without cr in a header line
        close_field();
        push_byte(mbd_pkg::CH_CR, 1'b0);
        push_byte(mbd_pkg::CH_LF, 1'b0);
        repeat ($urandom_range(0, 3)) push_byte(8'(8'h41 + $urandom_range(0, 25)), 1'b0);
        push_byte(mbd_pkg::CH_LF, 1'b0);
      end
    endcase
    // the block is idle now and must stay silent
    repeat (5) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    push_byte(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tag_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer byte %02h kind %0d last %0b",
                                  out_byte, out_kind, out_last));
      end else begin
        want = tag_queue.pop_front();
        if (out_byte !== want.data) begin
          report_mismatch($sformatf("byte %02h, predicted %02h", out_byte, want.data));
        end
        if (out_kind !== want.kind) begin
          report_mismatch($sformatf("kind %0d, predicted %s", out_kind, want.kind.name()));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %0b, predicted %0b", out_last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    in_stream_end <= 1'b0;
    fail_count = 0;
    sent = 0;
    gap_pct = 6;
    stall_pct = 59;
    form_phase = mbd_pkg::PH_LEARN;
    foreach (delim[i]) delim[i] = 8'h00;
    delim[0] = mbd_pkg::CH_CR;
    delim[1] = mbd_pkg::CH_LF;
    delim_len = 2;
    held = 0;
    line_len = 0;
    trail_first = 8'h00;
    saw_cr = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_boundary_line();
    test_edge_bytes();
    run_form(90);
    test_drain_pause();
    gap_pct = 59;
    stall_pct = 6;
    run_form(90);
    gap_pct = 0;
    stall_pct = 0;
    run_form(90);
    test_form_close();

    while (tag_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
